/* rtl/mmrp_pkg.sv */
// Shared types, constants and the CRC step for the meter reply parser.
`timescale 1ns / 1ps

package mmrp_pkg;

    localparam int FRAME_LEN = 25;
    localparam int CRC_SPAN  = 23;
    localparam int DATA_LEN  = 20;
    localparam int HDR_LEN   = 3;
    localparam int IDX_W     = 5;
    localparam int DAT_AW    = $clog2(DATA_LEN);
    localparam int QDEPTH    = 2;
    localparam int QAW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [15:0] ALARM_WORD = 16'hFFFF;
    localparam logic [7:0]  FUNC_CODE  = 8'h04;
    localparam logic [7:0]  BYTE_COUNT = 8'h14;
    localparam logic [7:0]  SLAVE_RST  = 8'h01;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_ADDR       = 3'd1;
    localparam logic [2:0] ST_FUNC       = 3'd2;
    localparam logic [2:0] ST_COUNT      = 3'd3;
    localparam logic [2:0] ST_CRC        = 3'd4;
    localparam logic [2:0] ST_INCOMPLETE = 3'd5;

    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    localparam logic CFG_SLAVE_ADDR = 1'b0;

    // One queued beat, already tagged with its place in the frame.
    typedef struct packed {
        logic             timeout;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
        logic [2:0]       hdr_err;
    } t_entry;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/mmrp_front.sv */
// Front end: takes input beats, tracks frame position and checks header bytes.
`timescale 1ns / 1ps

module mmrp_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_req_type,
    input  logic [7:0]            i_rx_byte,
    input  logic [7:0]            i_slave_addr,
    input  logic                  i_q_ready,
    output logic                  o_ready,
    output logic                  o_push,
    output mmrp_pkg::t_entry      o_entry
);

    logic [mmrp_pkg::IDX_W-1:0] r_idx;
    logic [mmrp_pkg::IDX_W-1:0] n_idx;
    logic                       accept;
    logic                       is_timeout;
    logic                       is_last;
    logic [2:0]                 hdr_err;

    assign accept     = i_valid && i_q_ready;
    assign is_timeout = (i_req_type == mmrp_pkg::REQ_TIMEOUT);
    assign is_last    = (r_idx == mmrp_pkg::IDX_W'(mmrp_pkg::FRAME_LEN - 1));

    always_comb begin
        hdr_err = mmrp_pkg::ST_OK;
        if (!is_timeout) begin
            priority if (r_idx == mmrp_pkg::IDX_W'(0)) begin
                if (i_rx_byte != i_slave_addr) hdr_err = mmrp_pkg::ST_ADDR;
            end else if (r_idx == mmrp_pkg::IDX_W'(1)) begin
                if (i_rx_byte != mmrp_pkg::FUNC_CODE) hdr_err = mmrp_pkg::ST_FUNC;
            end else if (r_idx == mmrp_pkg::IDX_W'(2)) begin
                if (i_rx_byte != mmrp_pkg::BYTE_COUNT) hdr_err = mmrp_pkg::ST_COUNT;
            end else begin
                hdr_err = mmrp_pkg::ST_OK;
            end
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (accept) begin
            if (is_timeout || is_last) begin
                n_idx = '0;
            end else begin
                n_idx = r_idx + mmrp_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    assign o_ready         = i_q_ready;
    assign o_push          = accept;
    assign o_entry.timeout = is_timeout;
    assign o_entry.idx     = r_idx;
    assign o_entry.data    = i_rx_byte;
    assign o_entry.hdr_err = hdr_err;

endmodule

/* rtl/mmrp_fifo.sv */
// Short queue of tagged beats between the front and back ends.
`timescale 1ns / 1ps

module mmrp_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mmrp_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_ready,
    output logic             o_valid,
    output mmrp_pkg::t_entry o_entry
);

    mmrp_pkg::t_entry         r_mem [mmrp_pkg::QDEPTH];
    logic [mmrp_pkg::QAW-1:0] r_wptr;
    logic [mmrp_pkg::QAW-1:0] r_rptr;
    logic [mmrp_pkg::QAW:0]   r_count;
    logic [mmrp_pkg::QAW-1:0] n_wptr;
    logic [mmrp_pkg::QAW-1:0] n_rptr;
    logic [mmrp_pkg::QAW:0]   n_count;
    logic                     do_push;
    logic                     do_pop;

    assign o_ready = (r_count != (mmrp_pkg::QAW + 1)'(mmrp_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == mmrp_pkg::QAW'(mmrp_pkg::QDEPTH - 1)) ? '0
                   : r_wptr + mmrp_pkg::QAW'(1);
        end
        if (do_pop) begin
            n_rptr = (r_rptr == mmrp_pkg::QAW'(mmrp_pkg::QDEPTH - 1)) ? '0
                   : r_rptr + mmrp_pkg::QAW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + (mmrp_pkg::QAW + 1)'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - (mmrp_pkg::QAW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

/* rtl/mmrp_back.sv */
// Back end: CRC, payload capture, frame verdict and the result register.
`timescale 1ns / 1ps

module mmrp_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  mmrp_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [4:0]       o_bytes_received,
    output logic [15:0]      o_voltage_raw,
    output logic [31:0]      o_current_raw,
    output logic [31:0]      o_power_raw,
    output logic [31:0]      o_energy_raw,
    output logic [15:0]      o_frequency_raw,
    output logic [15:0]      o_power_factor_raw,
    output logic             o_device_alarm
);

    logic [15:0] r_crc;
    logic [2:0]  r_err;
    logic [7:0]  r_crc_lo;
    logic [7:0]  r_data [mmrp_pkg::DATA_LEN];
    logic        r_out_valid;
    logic [2:0]  r_status;
    logic [4:0]  r_bytes;
    logic [15:0] r_volt;
    logic [31:0] r_curr;
    logic [31:0] r_pow;
    logic [31:0] r_energy;
    logic [15:0] r_freq;
    logic [15:0] r_pf;
    logic        r_alarm;

    logic        pop;
    logic        is_last;
    logic        in_crc;
    logic        in_data;
    logic        give;
    logic        frame_ok;
    logic [2:0]  verdict;
    logic [mmrp_pkg::DAT_AW-1:0] wr_addr;
    logic [mmrp_pkg::IDX_W-1:0]  idx_off;

    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign is_last = (i_entry.idx == mmrp_pkg::IDX_W'(mmrp_pkg::FRAME_LEN - 1));
    assign in_crc  = (i_entry.idx < mmrp_pkg::IDX_W'(mmrp_pkg::CRC_SPAN));
    assign in_data = in_crc && (i_entry.idx >= mmrp_pkg::IDX_W'(mmrp_pkg::HDR_LEN));
    assign idx_off = i_entry.idx - mmrp_pkg::IDX_W'(mmrp_pkg::HDR_LEN);
    assign wr_addr = idx_off[mmrp_pkg::DAT_AW-1:0];
    assign give    = pop && (i_entry.timeout || is_last);

    always_comb begin
        priority if (r_err != mmrp_pkg::ST_OK) begin
            verdict = r_err;
        end else if (r_crc != {i_entry.data, r_crc_lo}) begin
            verdict = mmrp_pkg::ST_CRC;
        end else begin
            verdict = mmrp_pkg::ST_OK;
        end
    end
    assign frame_ok = !i_entry.timeout && (verdict == mmrp_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= mmrp_pkg::CRC_INIT;
            r_err       <= mmrp_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                if (i_entry.timeout || is_last) begin
                    r_crc <= mmrp_pkg::CRC_INIT;
                    r_err <= mmrp_pkg::ST_OK;
                end else begin
                    if (in_crc) r_crc <= mmrp_pkg::crc_update(r_crc, i_entry.data);
                    if (r_err == mmrp_pkg::ST_OK) r_err <= i_entry.hdr_err;
                end
            end
            if (give) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && !i_entry.timeout) begin
            if (in_data) r_data[wr_addr] <= i_entry.data;
            if (i_entry.idx == mmrp_pkg::IDX_W'(mmrp_pkg::CRC_SPAN)) r_crc_lo <= i_entry.data;
        end
        if (give) begin
            r_status <= i_entry.timeout ? mmrp_pkg::ST_INCOMPLETE : verdict;
            r_bytes  <= i_entry.timeout ? i_entry.idx : 5'(mmrp_pkg::FRAME_LEN);
            r_volt   <= frame_ok ? {r_data[0], r_data[1]} : '0;
            r_curr   <= frame_ok ? {r_data[2], r_data[3], r_data[4], r_data[5]} : '0;
            r_pow    <= frame_ok ? {r_data[6], r_data[7], r_data[8], r_data[9]} : '0;
            r_energy <= frame_ok ? {r_data[10], r_data[11], r_data[12], r_data[13]} : '0;
            r_freq   <= frame_ok ? {r_data[14], r_data[15]} : '0;
            r_pf     <= frame_ok ? {r_data[16], r_data[17]} : '0;
            r_alarm  <= frame_ok && ({r_data[18], r_data[19]} == mmrp_pkg::ALARM_WORD);
        end
    end

    assign o_pop              = pop;
    assign o_valid            = r_out_valid;
    assign o_status           = r_status;
    assign o_bytes_received   = r_bytes;
    assign o_voltage_raw      = r_volt;
    assign o_current_raw      = r_curr;
    assign o_power_raw        = r_pow;
    assign o_energy_raw       = r_energy;
    assign o_frequency_raw    = r_freq;
    assign o_power_factor_raw = r_pf;
    assign o_device_alarm     = r_alarm;

endmodule

/* rtl/modbus_meter_response_parser.sv */
// Top level of the Modbus-RTU meter reply parser with its register port.
//
//  channel   direction  handshake          payload
//  input     in         i_valid/o_ready    i_req_type, i_rx_byte
//  result    out        o_valid/i_ready    o_status .. o_device_alarm
//  config    in         APB psel/penable   paddr, pwdata, prdata
//
// One beat per cycle is accepted while the queue has room; the queue lets input
// flow while a result waits. A last byte or timeout beat passes through the queue
// and then the back-end result register before its result leaves. CRC is one
// unrolled byte step. Reset is synchronous; no memory clearing is needed. Input
// stalls only when the queue is full, which needs a stalled result register.
`timescale 1ns / 1ps

module modbus_meter_response_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [4:0]  o_bytes_received,
    output logic [15:0] o_voltage_raw,
    output logic [31:0] o_current_raw,
    output logic [31:0] o_power_raw,
    output logic [31:0] o_energy_raw,
    output logic [15:0] o_frequency_raw,
    output logic [15:0] o_power_factor_raw,
    output logic        o_device_alarm
);

    logic [7:0]       r_slave_addr;
    logic             q_ready;
    logic             q_valid;
    logic             push;
    logic             pop;
    mmrp_pkg::t_entry push_entry;
    mmrp_pkg::t_entry pop_entry;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= mmrp_pkg::SLAVE_RST;
        end else if (i_psel && i_penable && i_pwrite
                     && i_paddr[2] == mmrp_pkg::CFG_SLAVE_ADDR) begin
            r_slave_addr <= i_pwdata[7:0];
        end
    end

    assign o_prdata = (i_paddr[2] == mmrp_pkg::CFG_SLAVE_ADDR) ? {24'h0, r_slave_addr} : '0;

    mmrp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_req_type   (i_req_type),
        .i_rx_byte    (i_rx_byte),
        .i_slave_addr (r_slave_addr),
        .i_q_ready    (q_ready),
        .o_ready      (o_ready),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    mmrp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_entry (pop_entry)
    );

    mmrp_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_entry            (pop_entry),
        .o_pop              (pop),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_bytes_received   (o_bytes_received),
        .o_voltage_raw      (o_voltage_raw),
        .o_current_raw      (o_current_raw),
        .o_power_raw        (o_power_raw),
        .o_energy_raw       (o_energy_raw),
        .o_frequency_raw    (o_frequency_raw),
        .o_power_factor_raw (o_power_factor_raw),
        .o_device_alarm     (o_device_alarm)
    );

    // failed frames carry no measurements
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != mmrp_pkg::ST_OK |->
            o_voltage_raw == '0 && o_current_raw == '0 && o_power_raw == '0
            && o_energy_raw == '0 && o_frequency_raw == '0
            && o_power_factor_raw == '0 && !o_device_alarm)
        else $error("measurement fields set on failed frame");

    // a verdict other than incomplete only comes from a full frame
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != mmrp_pkg::ST_INCOMPLETE |->
            o_bytes_received == 5'(mmrp_pkg::FRAME_LEN))
        else $error("verdict on short frame");

    // a popped last byte or timeout always lands in the result register
    a_give: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && (pop_entry.timeout
                || pop_entry.idx == mmrp_pkg::IDX_W'(mmrp_pkg::FRAME_LEN - 1)) |=> o_valid)
        else $error("result lost");

endmodule
